@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL modules; smi_dp includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Antecedent implies the consequent at the following clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/smi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package smi_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  localparam logic [31:0] SLACK_RESET = 32'd3600;

  typedef struct packed {
    logic [31:0] stream_tag;
    logic [31:0] start_req;
    logic [31:0] finish;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_stream;
    logic [31:0] out_start;
    logic [31:0] out_finish;
    logic        last_of_run;
    logic        overflowed;
  } out_item_t;

  typedef struct packed {
    logic [31:0] start_v;
    logic [31:0] end_v;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_PUSH,
    ST_PRE_RD,
    ST_PRE_OUT,
    ST_FIN_RD,
    ST_FIN_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // take the input transfer
    logic eval;       // merge or push within the open run
    logic push_new;   // open a new run with the held interval
    logic pop;        // read and remove the top entry
    logic fin_phase;  // pop belongs to the final drain
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic new_run;
    logic cnt_zero;
    logic in_last;
  } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/smi_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module smi_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire smi_pkg::status_t sts,
  output smi_pkg::cmd_t        cmd
);

  smi_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      smi_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = smi_pkg::ST_EVAL;
      end
      smi_pkg::ST_EVAL: begin
        if (sts.new_run) begin
          state_nxt = sts.cnt_zero ? smi_pkg::ST_PUSH : smi_pkg::ST_PRE_RD;
        end else begin
          state_nxt = sts.in_last ? smi_pkg::ST_FIN_RD : smi_pkg::ST_IDLE;
        end
      end
      smi_pkg::ST_PUSH: begin
        state_nxt = sts.in_last ? smi_pkg::ST_FIN_RD : smi_pkg::ST_IDLE;
      end
      smi_pkg::ST_PRE_RD: state_nxt = smi_pkg::ST_PRE_OUT;
      smi_pkg::ST_PRE_OUT: begin
        if (!out_stall) begin
          state_nxt = sts.cnt_zero ? smi_pkg::ST_PUSH : smi_pkg::ST_PRE_RD;
        end
      end
      smi_pkg::ST_FIN_RD: state_nxt = smi_pkg::ST_FIN_OUT;
      smi_pkg::ST_FIN_OUT: begin
        if (!out_stall) begin
          state_nxt = sts.cnt_zero ? smi_pkg::ST_IDLE : smi_pkg::ST_FIN_RD;
        end
      end
      default: state_nxt = smi_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      smi_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      smi_pkg::ST_EVAL:    cmd.eval     = ~sts.new_run;
      smi_pkg::ST_PUSH:    cmd.push_new = 1'b1;
      smi_pkg::ST_PRE_RD:  cmd.pop      = 1'b1;
      smi_pkg::ST_PRE_OUT: out_valid    = 1'b1;
      smi_pkg::ST_FIN_RD: begin
        cmd.pop       = 1'b1;
        cmd.fin_phase = 1'b1;
      end
      smi_pkg::ST_FIN_OUT: out_valid = 1'b1;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/smi_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module smi_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_wdata,
  input  wire smi_pkg::in_item_t in_data,
  input  wire smi_pkg::cmd_t     cmd,
  output smi_pkg::status_t       sts,
  output smi_pkg::out_item_t     out_data
);

  logic [31:0]                slack_r;
  logic [31:0]                sid_r, st_r, en_r;
  logic                       last_r;
  logic [31:0]                stream_r;
  logic                       have_prev_r;
  logic [smi_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       ovf_r;
  logic [31:0]                top_start_r, top_end_r;
  smi_pkg::entry_t            rd_data_r;
  logic                       rd_last_r;

  smi_pkg::entry_t            mem [smi_pkg::STACK_DEPTH];
  logic                       wr_en;
  logic [smi_pkg::IDX_W-1:0]  wr_idx;
  smi_pkg::entry_t            wr_data;

  logic [smi_pkg::CNT_W-1:0]  cnt_dec;
  logic [31:0]                top_end_inc;
  logic                       gap, widen, full;

  assign cnt_dec     = cnt_r - smi_pkg::CNT_W'(1);
  assign top_end_inc = top_end_r + 32'd1;
  assign gap         = top_end_inc < st_r;
  assign widen       = top_end_r < en_r;
  assign full        = cnt_r == smi_pkg::CNT_W'(smi_pkg::STACK_DEPTH);

  // Status to controller
  assign sts.new_run  = ~have_prev_r | (cnt_r == '0) | (sid_r != stream_r);
  assign sts.cnt_zero = cnt_r == '0;
  assign sts.in_last  = last_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slack_r <= smi_pkg::SLACK_RESET;
    end else if (cfg_we) begin
      slack_r <= cfg_wdata;
    end
  end

  // Hold the accepted interval, end extended by slack
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sid_r  <= in_data.stream_tag;
      st_r   <= in_data.start_req;
      en_r   <= in_data.finish + slack_r;
      last_r <= in_data.is_last;
    end
  end

  // Stack write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = cnt_r[smi_pkg::IDX_W-1:0];
    wr_data = '{start_v: st_r, end_v: en_r};
    if (cmd.push_new) begin
      wr_en = 1'b1;
    end else if (cmd.eval) begin
      if (gap) begin
        wr_en = ~full;
      end else if (widen) begin
        wr_en   = 1'b1;
        wr_idx  = cnt_dec[smi_pkg::IDX_W-1:0];
        wr_data = '{start_v: top_start_r, end_v: en_r};
      end
    end
  end

  // Stack memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      rd_data_r <= mem[cnt_dec[smi_pkg::IDX_W-1:0]];
      rd_last_r <= (cnt_dec == '0) & (cmd.fin_phase | ~last_r);
    end
  end

  // Top of stack copy
  always_ff @(posedge clk) begin
    if (cmd.push_new || (cmd.eval && gap && !full)) begin
      top_start_r <= st_r;
      top_end_r   <= en_r;
    end else if (cmd.eval && !gap && widen) begin
      top_end_r <= en_r;
    end
  end

  // Count: advance on push, drop on pop
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.pop) begin
      cnt_nxt = cnt_dec;
    end else if (cmd.push_new || (cmd.eval && gap && !full)) begin
      cnt_nxt = cnt_r + smi_pkg::CNT_W'(1);
    end
  end

  // Run state and sticky overflow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      have_prev_r <= 1'b0;
      stream_r    <= '0;
      ovf_r       <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.push_new) begin
        stream_r    <= sid_r;
        have_prev_r <= 1'b1;
      end else if (cmd.pop && cmd.fin_phase) begin
        have_prev_r <= 1'b0;
      end
      if (cmd.eval && gap && full) ovf_r <= 1'b1;
    end
  end

  // Result transfer payload
  assign out_data = '{out_stream:  stream_r,
                      out_start:   rd_data_r.start_v,
                      out_finish:  rd_data_r.end_v,
                      last_of_run: rd_last_r,
                      overflowed:  ovf_r};

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= smi_pkg::CNT_W'(smi_pkg::STACK_DEPTH))
  `ASSERT_NEXT(a_ovf_sticky, clk, rst_n, ovf_r, ovf_r)
  `ASSERT_IMPLY(a_pop_nonempty, clk, rst_n, cmd.pop, cnt_r != '0)
  `ASSERT_IMPLY(a_push_empty, clk, rst_n, cmd.push_new, cnt_r == '0)

endmodule
`default_nettype wire

@@ hw/rtl/sorted_interval_merger.sv @@
// An accepted interval that yields no result passes through IDLE and EVAL (merge or push within a run),
//   and through PUSH as well when it opens a new run on an empty stack; the stack sits in a registered RAM.
// Each result takes a RAM read (PRE_RD or FIN_RD), then an output transfer (PRE_OUT or FIN_OUT) held by out_stall.
// in_stall is low only in IDLE, so no new interval is taken until the last one and its drained entries are done.
// Reset: synchronous, active low; stack empty, overflow clear, merge_slack back to 3600.
`timescale 1ns / 1ps
`default_nettype none
module sorted_interval_merger (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire smi_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output smi_pkg::out_item_t      out_data
);

  smi_pkg::cmd_t    cmd;
  smi_pkg::status_t sts;

  smi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  smi_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
